// ===== design/perwm_pkg.sv =====
// Package for the peak event rate window monitor.
// Holds the field types, register indexes and the sequencer state type.
// No dependencies.
package perwm_pkg;

    localparam int TS_W      = 48;
    localparam int LEN_W     = 16;
    localparam int BYTES_W   = 40;
    localparam int EVENTS_W  = 32;
    localparam int RATE_W    = 11;
    localparam int WLEN_W    = 32;
    localparam int APB_ADDR_W = 5;
    localparam int APB_DATA_W = 64;

    typedef logic [TS_W-1:0]       t_ts;
    typedef logic [LEN_W-1:0]      t_len;
    typedef logic [BYTES_W-1:0]    t_bytes;
    typedef logic [EVENTS_W-1:0]   t_events;
    typedef logic [RATE_W-1:0]     t_rate;
    typedef logic [WLEN_W-1:0]     t_wlen;
    typedef logic [APB_ADDR_W-1:0] t_apb_addr;
    typedef logic [APB_DATA_W-1:0] t_apb_data;
    typedef logic [1:0]            t_cfg_idx;

    localparam t_cfg_idx CFG_CUTOFF_TIME   = 2'd0;
    localparam t_cfg_idx CFG_CUTOFF_ENABLE = 2'd1;
    localparam t_cfg_idx CFG_WINDOW_LENGTH = 2'd2;

    localparam t_wlen WINDOW_LENGTH_RESET = 32'd60000000;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CHECK,
        S_DONE
    } t_state;

endpackage

// ===== design/perwm_if.sv =====
// Handshake interfaces for the event input and the result output channels.
// Depends on perwm_pkg for the field types.
interface perwm_evt_if;
    import perwm_pkg::*;

    logic valid;
    logic ready;
    t_ts  timestamp_us;
    t_len line_bytes;
    logic scan_start;

    modport source (output valid, output timestamp_us, output line_bytes,
                    output scan_start, input ready);
    modport sink   (input valid, input timestamp_us, input line_bytes,
                    input scan_start, output ready);
endinterface

interface perwm_res_if;
    import perwm_pkg::*;

    logic    valid;
    logic    ready;
    t_bytes  byte_total;
    t_events entry_total;
    t_rate   peak_rate;
    t_rate   window_count;
    logic    scan_stopped;
    logic    window_overflow;

    modport source (output valid, output byte_total, output entry_total,
                    output peak_rate, output window_count, output scan_stopped,
                    output window_overflow, input ready);
    modport sink   (input valid, input byte_total, input entry_total,
                    input peak_rate, input window_count, input scan_stopped,
                    input window_overflow, output ready);
endinterface

// ===== design/peak_event_rate_window_monitor.sv =====
// Top level of the peak event rate window monitor.
// Depends on perwm_pkg and the channel interfaces in perwm_if.sv.
//
// Events enter on i_evt, newest first, and each produces one result transaction
// on o_res with the running byte and event totals, the current window count,
// the peak window count and the stop and overflow flags. Registers are written
// through the APB port at byte addresses 0 (cutoff time), 8 (cutoff enable)
// and 16 (window length), and should only be written while the block is idle.
// The window timestamps live in a single-port-write, single-port-read memory
// with a registered read. On acceptance an event pushes its timestamp and
// fetches the oldest entry; the check state then compares that entry against
// the window. Each entry that lies outside the window is popped and the next
// one fetched and compared, until an entry lies inside or a single entry is
// left. An event skips the check when the window holds one entry after the
// push or the scan is stopped.
// The result sits in an output register; a new event is accepted while it
// waits. When the receiver stalls and a second result is ready, the block
// holds in a done state and accepts nothing until the register frees up.
// Reset clears the window, all totals and flags and restores the register
// defaults. No clearing pass is needed after reset.
module peak_event_rate_window_monitor #(
    parameter int WINDOW_DEPTH = 1024
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    perwm_evt_if.sink              i_evt,
    perwm_res_if.source            o_res,
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  perwm_pkg::t_apb_addr   paddr,
    input  perwm_pkg::t_apb_data   pwdata,
    output perwm_pkg::t_apb_data   prdata,
    output logic                   pready
);
    import perwm_pkg::*;

    localparam int AW    = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
    localparam int OCC_W = $clog2(WINDOW_DEPTH + 1);

    typedef logic [AW-1:0]    t_ptr;
    typedef logic [OCC_W-1:0] t_occ;

    function automatic t_ptr f_next(input t_ptr p);
        return (p == AW'(WINDOW_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    function automatic t_rate f_rate(input t_occ v);
        logic [OCC_W+RATE_W-1:0] ext;
        ext = {{RATE_W{1'b0}}, v};
        return ext[RATE_W-1:0];
    endfunction

    // Configuration registers.
    t_ts   r_cutoff_time;
    logic  r_cutoff_enable;
    t_wlen r_window_length;

    // Scan state.
    t_state  r_state, n_state;
    t_ptr    r_head, n_head;
    t_ptr    r_tail, n_tail;
    t_occ    r_occ, n_occ;
    t_occ    r_peak, n_peak;
    t_bytes  r_bytes, n_bytes;
    t_events r_events, n_events;
    logic    r_stop, n_stop;
    logic    r_ovf, n_ovf;
    t_ts     r_last, n_last;
    t_ts     r_ts, n_ts;

    // Window memory.
    t_ts  r_window_mem [WINDOW_DEPTH];
    t_ts  r_rd;
    logic mem_we;
    t_ptr mem_waddr;

    // Output register.
    logic    r_out_valid;
    t_bytes  r_out_bytes;
    t_events r_out_events;
    t_rate   r_out_peak;
    t_rate   r_out_count;
    logic    r_out_stop;
    logic    r_out_ovf;

    logic    accept;
    logic    out_free;
    logic    load_out;
    logic    finish;
    logic    cfg_write;
    t_cfg_idx cfg_idx;

    t_occ    e_occ;
    t_ptr    e_head, e_tail;
    logic    hit_cutoff;
    logic [BYTES_W:0] byte_sum;
    logic [TS_W-1:0]  age;

    assign cfg_write = psel & penable & pwrite & pready;
    assign cfg_idx   = paddr[4:3];
    assign pready    = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cutoff_time   <= '0;
            r_cutoff_enable <= 1'b0;
            r_window_length <= WINDOW_LENGTH_RESET;
        end else if (cfg_write) begin
            case (cfg_idx)
                CFG_CUTOFF_TIME: begin
                    r_cutoff_time <= pwdata[TS_W-1:0];
                end
                CFG_CUTOFF_ENABLE: begin
                    r_cutoff_enable <= pwdata[0];
                end
                CFG_WINDOW_LENGTH: begin
                    r_window_length <= pwdata[WLEN_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            CFG_CUTOFF_TIME:   prdata = {{(APB_DATA_W-TS_W){1'b0}}, r_cutoff_time};
            CFG_CUTOFF_ENABLE: prdata = {{(APB_DATA_W-1){1'b0}}, r_cutoff_enable};
            CFG_WINDOW_LENGTH: prdata = {{(APB_DATA_W-WLEN_W){1'b0}}, r_window_length};
            default:           prdata = '0;
        endcase
    end

    assign accept      = i_evt.valid & (r_state == S_IDLE);
    assign i_evt.ready = (r_state == S_IDLE);
    assign out_free    = ~r_out_valid | o_res.ready;
    assign age         = r_rd - r_ts;

    always_comb begin
        n_state    = r_state;
        n_head     = r_head;
        n_tail     = r_tail;
        n_occ      = r_occ;
        n_peak     = r_peak;
        n_bytes    = r_bytes;
        n_events   = r_events;
        n_stop     = r_stop;
        n_ovf      = r_ovf;
        n_last     = r_last;
        n_ts       = r_ts;
        mem_we     = 1'b0;
        mem_waddr  = r_tail;
        finish     = 1'b0;
        load_out   = 1'b0;
        e_occ      = r_occ;
        e_head     = r_head;
        e_tail     = r_tail;
        hit_cutoff = 1'b0;
        byte_sum   = '0;

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (i_evt.scan_start) begin
                        e_occ    = '0;
                        e_head   = '0;
                        e_tail   = '0;
                        n_bytes  = '0;
                        n_events = '0;
                        n_peak   = '0;
                        n_stop   = 1'b0;
                        n_ovf    = 1'b0;
                    end
                    n_occ  = e_occ;
                    n_head = e_head;
                    n_tail = e_tail;
                    hit_cutoff = r_cutoff_enable & (i_evt.timestamp_us < r_cutoff_time);
                    if (n_stop | hit_cutoff) begin
                        n_stop = 1'b1;
                        finish = 1'b1;
                    end else begin
                        byte_sum = {1'b0, n_bytes} + {{(BYTES_W-LEN_W+1){1'b0}},
                                   i_evt.line_bytes} + 1'b1;
                        n_bytes  = byte_sum[BYTES_W] ? '1 : byte_sum[BYTES_W-1:0];
                        if (n_events != '1) begin
                            n_events = n_events + 1'b1;
                        end
                        if ((e_occ != '0) && (r_last < i_evt.timestamp_us)) begin
                            n_occ  = '0;
                            n_head = '0;
                            n_tail = '0;
                        end
                        if (n_occ == OCC_W'(WINDOW_DEPTH)) begin
                            n_head = f_next(n_head);
                            n_occ  = n_occ - 1'b1;
                            n_ovf  = 1'b1;
                        end
                        mem_we    = 1'b1;
                        mem_waddr = n_tail;
                        n_tail    = f_next(n_tail);
                        n_occ     = n_occ + 1'b1;
                        n_last    = i_evt.timestamp_us;
                        n_ts      = i_evt.timestamp_us;
                        if (n_occ > OCC_W'(1)) begin
                            n_state = S_CHECK;
                        end else begin
                            finish = 1'b1;
                        end
                    end
                end
            end
            S_CHECK: begin
                if (age > {{(TS_W-WLEN_W){1'b0}}, r_window_length}) begin
                    n_head = f_next(r_head);
                    n_occ  = r_occ - 1'b1;
                    if (n_occ <= OCC_W'(1)) begin
                        finish = 1'b1;
                    end
                end else begin
                    finish = 1'b1;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    load_out = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (finish) begin
            if (n_occ > n_peak) begin
                n_peak = n_occ;
            end
            if (out_free) begin
                load_out = 1'b1;
                n_state  = S_IDLE;
            end else begin
                n_state  = S_DONE;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_head   <= '0;
            r_tail   <= '0;
            r_occ    <= '0;
            r_peak   <= '0;
            r_bytes  <= '0;
            r_events <= '0;
            r_stop   <= 1'b0;
            r_ovf    <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_head   <= n_head;
            r_tail   <= n_tail;
            r_occ    <= n_occ;
            r_peak   <= n_peak;
            r_bytes  <= n_bytes;
            r_events <= n_events;
            r_stop   <= n_stop;
            r_ovf    <= n_ovf;
        end
    end

    always_ff @(posedge i_clk) begin
        r_last <= n_last;
        r_ts   <= n_ts;
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_window_mem[mem_waddr] <= i_evt.timestamp_us;
        end
        r_rd <= r_window_mem[n_head];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_out) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out_bytes  <= n_bytes;
            r_out_events <= n_events;
            r_out_peak   <= f_rate(n_peak);
            r_out_count  <= f_rate(n_occ);
            r_out_stop   <= n_stop;
            r_out_ovf    <= n_ovf;
        end
    end

    assign o_res.valid           = r_out_valid;
    assign o_res.byte_total      = r_out_bytes;
    assign o_res.entry_total     = r_out_events;
    assign o_res.peak_rate       = r_out_peak;
    assign o_res.window_count    = r_out_count;
    assign o_res.scan_stopped    = r_out_stop;
    assign o_res.window_overflow = r_out_ovf;

    a_occ_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_occ <= OCC_W'(WINDOW_DEPTH))
        else $error("Window occupancy exceeds the store depth.");

    a_check_occ: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CHECK) |-> (r_occ > OCC_W'(1)))
        else $error("Window check runs with fewer than two entries.");

    a_peak_cover: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (r_peak >= r_occ))
        else $error("Peak rate is below the current window count.");

    a_accept_progress: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> ((r_state != S_IDLE) || r_out_valid))
        else $error("Accepted transaction left no work and no result.");

    a_done_waits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE) |-> r_out_valid)
        else $error("Done state entered while the output register was free.");

endmodule

// ===== verif/peak_event_rate_window_monitor_tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for peak_event_rate_window_monitor: drives log events, predicts every
// result transaction from a behavioral copy of the window FIFO and compares field by field.
// Depends on perwm_pkg, the channel interfaces in perwm_if.sv and the design top level.
module peak_event_rate_window_monitor_tb;
    import perwm_pkg::*;

    localparam int unsigned WIN_DEPTH = 1024;
    localparam t_ts TS_MAX = '1;

    typedef struct {
        t_ts  ts;
        t_len len;
        logic start;
    } t_log_event;

    typedef struct packed {
        t_bytes  byte_total;
        t_events entry_total;
        t_rate   peak_rate;
        t_rate   window_count;
        logic    scan_stopped;
        logic    window_overflow;
    } t_scan_result;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      psel = 1'b0;
    logic      penable = 1'b0;
    logic      pwrite = 1'b0;
    t_apb_addr paddr = '0;
    t_apb_data pwdata = '0;
    t_apb_data prdata;
    logic      pready;

    logic evt_valid = 1'b0;
    t_ts  evt_ts = '0;
    t_len evt_len = '0;
    logic evt_start = 1'b0;
    logic res_ready = 1'b0;

    perwm_evt_if evt_ch ();
    perwm_res_if res_ch ();

    assign evt_ch.valid        = evt_valid;
    assign evt_ch.timestamp_us = evt_ts;
    assign evt_ch.line_bytes   = evt_len;
    assign evt_ch.scan_start   = evt_start;
    assign res_ch.ready        = res_ready;

    peak_event_rate_window_monitor #(
        .WINDOW_DEPTH(WIN_DEPTH)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_evt   (evt_ch),
        .o_res   (res_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #10 i_clk = ~i_clk;

    t_ts   cut_time = '0;
    logic  cut_en = 1'b0;
    t_wlen wlen = WINDOW_LENGTH_RESET;

    t_ts         win_ts [WIN_DEPTH];
    int unsigned win_head = 0;
    int unsigned win_tail = 0;
    int unsigned win_occ = 0;
    t_bytes      run_bytes = '0;
    t_events     run_events = '0;
    int unsigned run_peak = 0;
    logic        run_stopped = 1'b0;
    logic        run_overflow = 1'b0;

    t_log_event   event_backlog [$];
    t_scan_result expected_totals [$];

    int unsigned src_idle_pct = 0;
    int unsigned snk_stall_pct = 0;
    int unsigned hold_requests = 0;
    int unsigned hold_served = 0;
    int unsigned hold_left = 0;
    int unsigned mismatches = 0;
    int unsigned results_seen = 0;

    function automatic int unsigned wrap_inc(int unsigned idx);
        return (idx + 1 >= WIN_DEPTH) ? 0 : idx + 1;
    endfunction

    task automatic empty_window();
        win_head = 0;
        win_tail = 0;
        win_occ  = 0;
    endtask

    task automatic account_event(t_ts ts, t_len len, logic start);
        t_scan_result r;
        logic [BYTES_W:0] bsum;
        int unsigned last;
        if (start) begin
            empty_window();
            run_bytes    = '0;
            run_events   = '0;
            run_peak     = 0;
            run_stopped  = 1'b0;
            run_overflow = 1'b0;
        end
        if (!run_stopped && cut_en && ts < cut_time) begin
            run_stopped = 1'b1;
        end
        if (!run_stopped) begin
            bsum = {1'b0, run_bytes} + len + 41'd1;
            run_bytes = bsum[BYTES_W] ? '1 : bsum[BYTES_W-1:0];
            if (win_occ > 0) begin
                last = (win_tail == 0) ? WIN_DEPTH - 1 : win_tail - 1;
                if (win_ts[last] < ts) begin
                    empty_window();
                end
            end
            if (win_occ >= WIN_DEPTH) begin
                win_head = wrap_inc(win_head);
                win_occ--;
                run_overflow = 1'b1;
            end
            win_ts[win_tail] = ts;
            win_tail = wrap_inc(win_tail);
            win_occ++;
            while (win_occ > 0 && 64'(win_ts[win_head]) - 64'(ts) > 64'(wlen)) begin
                win_head = wrap_inc(win_head);
                win_occ--;
            end
            if (win_occ > run_peak) begin
                run_peak = win_occ;
            end
            if (run_events != '1) begin
                run_events++;
            end
        end
        r.byte_total      = run_bytes;
        r.entry_total     = run_events;
        r.peak_rate       = t_rate'(run_peak);
        r.window_count    = t_rate'(win_occ);
        r.scan_stopped    = run_stopped;
        r.window_overflow = run_overflow;
        expected_totals.insert(expected_totals.size(), r);
    endtask

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        mismatches++;
        $display("MISMATCH at result %0d: %s got 0x%0h expected 0x%0h",
                 results_seen, what, got, want);
    endtask

    task automatic compare_totals();
        t_scan_result want;
        if (expected_totals.size() == 0) begin
            report_mismatch("result with no event pending", 64'd0, 64'd0);
            return;
        end
        want = expected_totals[0];
        expected_totals.delete(0);
        if (res_ch.byte_total !== want.byte_total)
            report_mismatch("byte_total", 64'(res_ch.byte_total), 64'(want.byte_total));
        if (res_ch.entry_total !== want.entry_total)
            report_mismatch("entry_total", 64'(res_ch.entry_total), 64'(want.entry_total));
        if (res_ch.peak_rate !== want.peak_rate)
            report_mismatch("peak_rate", 64'(res_ch.peak_rate), 64'(want.peak_rate));
        if (res_ch.window_count !== want.window_count)
            report_mismatch("window_count", 64'(res_ch.window_count),
                            64'(want.window_count));
        if (res_ch.scan_stopped !== want.scan_stopped)
            report_mismatch("scan_stopped", 64'(res_ch.scan_stopped),
                            64'(want.scan_stopped));
        if (res_ch.window_overflow !== want.window_overflow)
            report_mismatch("window_overflow", 64'(res_ch.window_overflow),
                            64'(want.window_overflow));
        results_seen++;
    endtask

    always @(posedge i_clk) begin : event_driver
        t_log_event pending;
        logic accepted;
        if (!i_rst_n) begin
            evt_valid <= 1'b0;
        end else begin
            accepted = evt_valid && evt_ch.ready;
            if (accepted) begin
                account_event(evt_ts, evt_len, evt_start);
            end
            if (!evt_valid || accepted) begin
                if (event_backlog.size() != 0 && $urandom_range(0, 99) >= src_idle_pct) begin
                    pending = event_backlog[0];
                    event_backlog.delete(0);
                    evt_valid <= 1'b1;
                    evt_ts    <= pending.ts;
                    evt_len   <= pending.len;
                    evt_start <= pending.start;
                end else begin
                    evt_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin : result_monitor
        if (!i_rst_n) begin
            res_ready <= 1'b0;
        end else begin
            if (res_ch.valid && res_ready) begin
                compare_totals();
            end
            res_ready <= (hold_left == 0) && ($urandom_range(0, 99) >= snk_stall_pct);
        end
    end

    // A long receiver hold-off lets the block fill up and stall its input.
    always @(posedge i_clk) begin : sink_hold_off
        if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end else if (hold_served != hold_requests) begin
            hold_left   <= 600;
            hold_served <= hold_served + 1;
        end
    end

    task automatic write_register(t_cfg_idx idx, t_apb_data value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            CFG_CUTOFF_TIME:   cut_time = value[TS_W-1:0];
            CFG_CUTOFF_ENABLE: cut_en   = value[0];
            CFG_WINDOW_LENGTH: wlen     = value[WLEN_W-1:0];
            default: ;
        endcase
        @(negedge i_clk);
    endtask

    task automatic queue_event(t_ts ts, t_len len, logic start);
        t_log_event item;
        item.ts    = ts;
        item.len   = len;
        item.start = start;
        event_backlog.insert(event_backlog.size(), item);
    endtask

    task automatic wait_idle();
        do @(negedge i_clk);
        while (event_backlog.size() != 0 || evt_valid || expected_totals.size() != 0);
        repeat (8) @(posedge i_clk);
    endtask

    function automatic t_ts older_ts(t_ts ts);
        logic [63:0] gap;
        int unsigned pick;
        pick = $urandom_range(0, 9);
        if (pick < 3) gap = 64'd0;
        else if (pick < 8) gap = 64'($urandom_range(0, wlen >> 2));
        else if (pick == 8) gap = 64'(wlen);
        else gap = 64'(wlen) + 64'($urandom_range(1, 1000));
        return (64'(ts) < gap) ? '0 : t_ts'(64'(ts) - gap);
    endfunction

    function automatic t_ts scan_base();
        logic [63:0] base;
        if (cut_en) base = 64'(cut_time) + 64'($urandom_range(0, 40)) * 64'(wlen >> 1);
        else base = 64'(t_ts'({$urandom, $urandom}));
        return (base > 64'(TS_MAX)) ? TS_MAX : t_ts'(base);
    endfunction

    // Mostly well-formed scans, some with one timestamp out of order, plus random noise.
    task automatic queue_random_traffic(int unsigned n_items);
        int unsigned made;
        int unsigned run_len;
        int unsigned kind;
        t_ts ts;
        made = 0;
        while (made < n_items) begin
            kind = $urandom_range(0, 9);
            if (kind < 8) begin
                run_len = $urandom_range(1, 60);
                ts = scan_base();
                for (int unsigned k = 0; k < run_len; k++) begin
                    queue_event(ts, t_len'($urandom), k == 0);
                    ts = older_ts(ts);
                    if (kind == 7 && k == run_len / 2) begin
                        ts = (ts > TS_MAX - 48'd1000) ? TS_MAX
                                                      : ts + 48'($urandom_range(1, 1000));
                    end
                end
            end else begin
                run_len = $urandom_range(1, 8);
                for (int unsigned k = 0; k < run_len; k++) begin
                    queue_event(t_ts'({$urandom, $urandom}), t_len'($urandom),
                                $urandom_range(0, 3) == 0);
                end
            end
            made += run_len;
        end
    endtask

    initial begin : stimulus
        t_ts burst_ts;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Register defaults: no cutoff, one minute window.
        queue_event(TS_MAX, 16'hFFFF, 1'b1);
        queue_event(TS_MAX - 48'd1, 16'h0000, 1'b0);
        queue_event(TS_MAX - 48'd60000000, 16'h1234, 1'b0);
        queue_event(TS_MAX - 48'd60000001, 16'h00FF, 1'b0);
        queue_event(TS_MAX, 16'h8000, 1'b0);
        queue_event(48'd0, 16'h7FFF, 1'b0);
        queue_event(48'd0, 16'h0001, 1'b1);
        wait_idle();

        write_register(CFG_WINDOW_LENGTH, 64'd0);
        queue_event(48'd1000, 16'h0010, 1'b1);
        queue_event(48'd1000, 16'h0020, 1'b0);
        queue_event(48'd1000, 16'h0030, 1'b0);
        queue_event(48'd999, 16'h0040, 1'b0);
        queue_event(48'd999, 16'h0050, 1'b0);
        wait_idle();

        write_register(CFG_WINDOW_LENGTH, 64'hFFFF_FFFF);
        write_register(CFG_CUTOFF_TIME, 64'd5000);
        write_register(CFG_CUTOFF_ENABLE, 64'd1);
        queue_event(48'd10000, 16'h0100, 1'b1);
        queue_event(48'd5000, 16'h0200, 1'b0);
        queue_event(48'd4999, 16'h0300, 1'b0);
        queue_event(48'd6000, 16'h0400, 1'b0);
        queue_event(48'd4000, 16'h0500, 1'b1);
        queue_event(48'd5000, 16'h0600, 1'b1);
        wait_idle();

        write_register(CFG_CUTOFF_TIME, 64'(TS_MAX));
        queue_event(TS_MAX, 16'hFFFF, 1'b1);
        queue_event(TS_MAX - 48'd1, 16'hFFFF, 1'b0);
        queue_event(48'd0, 16'h0000, 1'b0);
        wait_idle();

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin
                    src_idle_pct  = 0;
                    snk_stall_pct = 0;
                    write_register(CFG_WINDOW_LENGTH, 64'd1000);
                    write_register(CFG_CUTOFF_ENABLE, 64'd0);
                end
                1: begin
                    src_idle_pct  = 73;
                    snk_stall_pct = 0;
                    write_register(CFG_WINDOW_LENGTH, 64'({$urandom} | 32'd1));
                    write_register(CFG_CUTOFF_TIME, 64'(t_ts'({$urandom, $urandom})));
                    write_register(CFG_CUTOFF_ENABLE, 64'd1);
                end
                2: begin
                    src_idle_pct  = 0;
                    snk_stall_pct = 73;
                    write_register(CFG_WINDOW_LENGTH, 64'($urandom_range(1, 5000)));
                    write_register(CFG_CUTOFF_TIME, 64'(t_ts'({$urandom, $urandom})));
                end
                default: begin
                    src_idle_pct  = 21;
                    snk_stall_pct = 21;
                    write_register(CFG_WINDOW_LENGTH, 64'hFFFF_FFFF);
                    write_register(CFG_CUTOFF_TIME, 64'(TS_MAX));
                    write_register(CFG_CUTOFF_ENABLE, 64'd0);
                end
            endcase
            if (phase == 0) begin
                // Equal timestamps overrun the window store; a receiver hold-off at the start stalls the input.
                burst_ts = t_ts'({$urandom, $urandom});
                hold_requests++;
                for (int k = 0; k <= 1040; k++) begin
                    queue_event(burst_ts, t_len'($urandom), k == 0);
                end
            end
            queue_random_traffic(300);
            wait_idle();
        end

        repeat (40) @(posedge i_clk);
        if (mismatches == 0 && expected_totals.size() == 0) begin
            $display("peak_event_rate_window_monitor regression: pass");
        end else begin
            $display("peak_event_rate_window_monitor regression: fail");
        end
        $finish;
    end

    initial begin : watchdog
        #20_000_000;
        $display("peak_event_rate_window_monitor regression: fail");
        $finish;
    end

endmodule
